FILE: sv/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types, codes and helpers for the graph burning step checker.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int VERTEX_W         = 6;
   localparam int COUNT_W          = 7;
   localparam int CMD_W            = 2;
   localparam int REQ_DATA_W       = 16;
   localparam int REQ_USER_W       = 2;
   localparam int RSP_DATA_W       = 8;
   localparam int RSP_USER_W       = 1;
   localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_EDGE = 2'd0,
      CMD_CLEAR    = 2'd1,
      CMD_BURN     = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EDGE_RD_A,
      ST_EDGE_WR_A,
      ST_EDGE_RD_B,
      ST_EDGE_WR_B,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_MERGE,
      ST_COUNT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic latch_item;
      logic clear_map;
      logic set_invalid;
      logic edge_rd_a;
      logic edge_wr_a;
      logic edge_rd_b;
      logic edge_wr_b;
      logic clear_spread;
      logic sweep_step;
      logic merge;
      logic count_step;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    a_ok;
      logic    b_ok;
      logic    src_burned;
      logic    sweep_last;
      logic    count_last;
      logic    rsp_free;
   } dp_stat_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + {3'b000, v[i]};
      end
      return c;
   endfunction

endpackage

FILE: sv/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/gbs_ctrl.sv
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: decodes each item and steps the datapath through edge update,
// adjacency sweep, merge, count and response.
// ----------------------------------------------------------------------------
module gbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  gbs_pkg::dp_stat_type  stat,
   output gbs_pkg::ctrl_cmd_type cmd
);
   import gbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_item = 1'b1;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.cmd)
               CMD_ADD_EDGE: begin
                  state_in = (stat.a_ok && stat.b_ok) ? ST_EDGE_RD_A : ST_RESP;
               end
               CMD_CLEAR: begin
                  cmd.clear_map = 1'b1;
                  state_in      = ST_RESP;
               end
               CMD_BURN: begin
                  if (!stat.a_ok) begin
                     state_in = ST_RESP;
                  end else if (stat.src_burned) begin
                     cmd.set_invalid = 1'b1;
                     state_in        = ST_RESP;
                  end else begin
                     cmd.clear_spread = 1'b1;
                     state_in         = ST_SWEEP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_EDGE_RD_A: begin
            cmd.edge_rd_a = 1'b1;
            state_in      = ST_EDGE_WR_A;
         end
         ST_EDGE_WR_A: begin
            cmd.edge_wr_a = 1'b1;
            state_in      = ST_EDGE_RD_B;
         end
         ST_EDGE_RD_B: begin
            cmd.edge_rd_b = 1'b1;
            state_in      = ST_EDGE_WR_B;
         end
         ST_EDGE_WR_B: begin
            cmd.edge_wr_b = 1'b1;
            state_in      = ST_RESP;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_SWEEP_END;
            end
         end
         // let the last row read land in the spread accumulator
         ST_SWEEP_END: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (stat.count_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/gbs_datapath.sv
// ----------------------------------------------------------------------------
// gbs_datapath
// Adjacency RAM with row valid bits, burned map, spread accumulator,
// chunked popcount, vertex count register and response register.
// ----------------------------------------------------------------------------
module gbs_datapath #(
   parameter int MAX_VERTICES = gbs_pkg::DEF_MAX_VERTICES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gbs_pkg::ctrl_cmd_type        cmd,
   output gbs_pkg::dp_stat_type         stat,
   input  gbs_pkg::cmd_type             item_cmd,
   input  logic [gbs_pkg::VERTEX_W-1:0] item_a,
   input  logic [gbs_pkg::VERTEX_W-1:0] item_b,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [gbs_pkg::COUNT_W-1:0]  csr_data,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_invalid,
   output logic                         rsp_all,
   output logic [gbs_pkg::COUNT_W-1:0]  rsp_count
);
   import gbs_pkg::*;

   localparam int AW     = $clog2(MAX_VERTICES);
   localparam int CHUNKS = (MAX_VERTICES + 7) / 8;
   localparam int CIW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int PADW   = CHUNKS * 8;
   localparam logic [MAX_VERTICES-1:0] ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

   cmd_type                 cmd_ff, cmd_in;
   logic [VERTEX_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic [MAX_VERTICES-1:0] burned_ff, burned_in;
   logic [MAX_VERTICES-1:0] spread_ff, spread_in;
   logic [MAX_VERTICES-1:0] row_valid_ff, row_valid_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]      vcount_ff, vcount_in;
   logic                    invalid_ff, invalid_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    acc_en_ff, acc_en_in;
   logic                    acc_gate_ff, acc_gate_in;
   logic [AW-1:0]           sweep_idx_ff, sweep_idx_in;
   logic [CIW-1:0]          chunk_idx_ff, chunk_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_invalid_ff, rsp_invalid_in;
   logic                    rsp_all_ff, rsp_all_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                    a_ok, b_ok;
   logic [MAX_VERTICES-1:0] onehot_a, onehot_b, row_q;
   logic [PADW-1:0]         burned_pad;
   logic                    ram_wr_en, ram_rd_en;
   logic [AW-1:0]           ram_wr_addr, ram_rd_addr;
   logic [MAX_VERTICES-1:0] ram_wr_data, ram_rd_data;

   assign a_ok       = {1'b0, a_ff} < COUNT_W'(MAX_VERTICES);
   assign b_ok       = {1'b0, b_ff} < COUNT_W'(MAX_VERTICES);
   assign onehot_a   = a_ok ? (ONE << a_ff) : '0;
   assign onehot_b   = b_ok ? (ONE << b_ff) : '0;
   assign row_q      = rd_valid_ff ? ram_rd_data : '0;
   assign burned_pad = PADW'(burned_ff);

   // RAM port steering
   always_comb begin
      ram_rd_en   = cmd.edge_rd_a | cmd.edge_rd_b | cmd.sweep_step;
      ram_rd_addr = sweep_idx_ff;
      if (cmd.edge_rd_a) begin
         ram_rd_addr = a_ff[AW-1:0];
      end else if (cmd.edge_rd_b) begin
         ram_rd_addr = b_ff[AW-1:0];
      end
      ram_wr_en   = cmd.edge_wr_a | cmd.edge_wr_b;
      ram_wr_addr = cmd.edge_wr_b ? b_ff[AW-1:0] : a_ff[AW-1:0];
      ram_wr_data = row_q | (cmd.edge_wr_b ? onehot_a : onehot_b);
   end

   gbs_ram #(
      .WIDTH (MAX_VERTICES),
      .DEPTH (MAX_VERTICES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      cmd_in         = cmd_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      burned_in      = burned_ff;
      spread_in      = spread_ff;
      row_valid_in   = row_valid_ff;
      count_in       = count_ff;
      vcount_in      = csr_valid ? csr_data : vcount_ff;
      invalid_in     = invalid_ff;
      rd_valid_in    = ram_rd_en ? row_valid_ff[ram_rd_addr] : rd_valid_ff;
      acc_en_in      = cmd.sweep_step;
      acc_gate_in    = burned_ff[sweep_idx_ff];
      sweep_idx_in   = sweep_idx_ff;
      chunk_idx_in   = chunk_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_invalid_in = rsp_invalid_ff;
      rsp_all_in     = rsp_all_ff;
      rsp_count_in   = rsp_count_ff;

      if (cmd.latch_item) begin
         cmd_in     = item_cmd;
         a_in       = item_a;
         b_in       = item_b;
         invalid_in = 1'b0;
      end
      if (cmd.set_invalid) begin
         invalid_in = 1'b1;
      end
      if (cmd.clear_map) begin
         burned_in = '0;
         count_in  = '0;
      end
      if (cmd.edge_wr_a) begin
         row_valid_in[a_ff[AW-1:0]] = 1'b1;
      end
      if (cmd.edge_wr_b) begin
         row_valid_in[b_ff[AW-1:0]] = 1'b1;
      end
      // only rows of vertices burned before the round feed the spread
      if (cmd.clear_spread) begin
         spread_in    = '0;
         sweep_idx_in = '0;
      end else if (acc_en_ff && acc_gate_ff) begin
         spread_in = spread_ff | row_q;
      end
      if (cmd.sweep_step) begin
         sweep_idx_in = sweep_idx_ff + AW'(1);
      end
      if (cmd.merge) begin
         burned_in    = burned_ff | spread_ff | onehot_a;
         count_in     = '0;
         chunk_idx_in = '0;
      end
      if (cmd.count_step) begin
         count_in     = count_ff + COUNT_W'(popcount8(burned_pad[chunk_idx_ff*8 +: 8]));
         chunk_idx_in = chunk_idx_ff + CIW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_invalid_in = invalid_ff;
         rsp_all_in     = (count_ff == vcount_ff);
         rsp_count_in   = count_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burned_ff    <= '0;
         row_valid_ff <= '0;
         count_ff     <= '0;
         vcount_ff    <= VCOUNT_RESET;
         invalid_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         acc_en_ff    <= 1'b0;
         sweep_idx_ff <= '0;
         chunk_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         burned_ff    <= burned_in;
         row_valid_ff <= row_valid_in;
         count_ff     <= count_in;
         vcount_ff    <= vcount_in;
         invalid_ff   <= invalid_in;
         rd_valid_ff  <= rd_valid_in;
         acc_en_ff    <= acc_en_in;
         sweep_idx_ff <= sweep_idx_in;
         chunk_idx_ff <= chunk_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      spread_ff      <= spread_in;
      acc_gate_ff    <= acc_gate_in;
      rsp_invalid_ff <= rsp_invalid_in;
      rsp_all_ff     <= rsp_all_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.a_ok       = a_ok;
      stat.b_ok       = b_ok;
      stat.src_burned = |(burned_ff & onehot_a);
      stat.sweep_last = (sweep_idx_ff == AW'(MAX_VERTICES - 1));
      stat.count_last = (chunk_idx_ff == CIW'(CHUNKS - 1));
      stat.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_invalid = rsp_invalid_ff;
   assign rsp_all     = rsp_all_ff;
   assign rsp_count   = rsp_count_ff;

endmodule

FILE: sv/graph_burning_step.sv
// ----------------------------------------------------------------------------
// graph_burning_step
// Burning sequence checker over an adjacency bit matrix held in RAM.
// One item at a time; a burn is set by the sweep that reads one adjacency row
// per cycle through the single RAM read port, then a popcount of 8 bits a cycle.
// A result may wait in the output register while the next item is taken.
// Synchronous reset clears map, row valid bits and control; vertex_count = 64.
// ----------------------------------------------------------------------------
module graph_burning_step #(
   parameter int MAX_VERTICES = gbs_pkg::DEF_MAX_VERTICES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [gbs_pkg::REQ_DATA_W-1:0] req_tdata,  // vertex_a, vertex_b, pad
   input  logic [gbs_pkg::REQ_USER_W-1:0] req_tuser,  // cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [gbs_pkg::RSP_DATA_W-1:0] rsp_tdata,  // all_burned, burned_count
   output logic [gbs_pkg::RSP_USER_W-1:0] rsp_tuser,  // invalid_source
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gbs_pkg::COUNT_W-1:0]    csr_data    // vertex_count
);
   import gbs_pkg::*;

   ctrl_cmd_type       cmd;
   dp_stat_type        stat;
   logic               rsp_invalid;
   logic               rsp_all;
   logic [COUNT_W-1:0] rsp_count;

   gbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gbs_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .item_cmd    (cmd_type'(req_tuser)),
      .item_a      (req_tdata[VERTEX_W-1:0]),
      .item_b      (req_tdata[2*VERTEX_W-1:VERTEX_W]),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_invalid (rsp_invalid),
      .rsp_all     (rsp_all),
      .rsp_count   (rsp_count)
   );

   assign rsp_tdata = {rsp_count, rsp_all};
   assign rsp_tuser = rsp_invalid;

   // an accepted item holds off the next transfer until its result is queued
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in flight");

   // never overwrite a result that has not been transferred
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.rsp_free)
      else $error("response register overwritten");

   // edge updates and the sweep share the RAM and must not overlap
   a_ram_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> !(cmd.edge_wr_a || cmd.edge_wr_b || cmd.edge_rd_a ||
                           cmd.edge_rd_b))
      else $error("edge update during sweep");

   // burned count cannot exceed the vertex capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_count <= COUNT_W'(MAX_VERTICES)))
      else $error("burned count out of range");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for graph_burning_step. Builds graphs from add-edge
// transfers, plays burning sequences over several vertex_count settings and
// compares each result with a bench-side predictor of the burned map.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic       invalid_source;
   logic       all_burned;
   logic [6:0] burned_count;
} burn_outcome_type;

class burn_scoreboard;
   logic [63:0]      adj_rows [64];
   logic [63:0]      burned;
   logic [6:0]       vertex_count;
   burn_outcome_type outcomes [$];
   int               mismatches;
   int               burns;
   int               invalid_burns;
   int               full_results;

   function new();
      for (int i = 0; i < 64; i++) begin
         adj_rows[i] = '0;
      end
      burned       = '0;
      vertex_count = gbs_pkg::VCOUNT_RESET;
      mismatches   = 0;
      burns        = 0;
      invalid_burns = 0;
      full_results = 0;
   endfunction

   function void set_vertex_count(logic [6:0] value);
      vertex_count = value;
   endfunction

   function int pending();
      return outcomes.size();
   endfunction

   // random vertex below span that is not yet burned, -1 if none is left
   function int pick_unburned(int span);
      int cand [$];
      for (int v = 0; v < span; v++) begin
         if (!burned[v]) cand.insert(cand.size(), v);
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   // play one accepted item against the graph and queue its outcome
   function void note_item(gbs_pkg::cmd_type cmd, logic [5:0] a, logic [5:0] b);
      burn_outcome_type o;
      logic [63:0]      spread;
      logic [6:0]       cnt;
      o.invalid_source = 1'b0;
      case (cmd)
         gbs_pkg::CMD_ADD_EDGE: begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
         end
         gbs_pkg::CMD_CLEAR: begin
            burned = '0;
         end
         gbs_pkg::CMD_BURN: begin
            burns++;
            if (burned[a]) begin
               o.invalid_source = 1'b1;
               invalid_burns++;
            end else begin
               spread = '0;
               for (int v = 0; v < 64; v++) begin
                  if (burned[v]) spread |= adj_rows[v];
               end
               burned = burned | spread | (64'd1 << a);
            end
         end
         default: begin
         end
      endcase
      cnt = '0;
      for (int v = 0; v < 64; v++) begin
         cnt += {6'd0, burned[v]};
      end
      o.burned_count = cnt;
      o.all_burned   = (cnt == vertex_count);
      if (o.all_burned) full_results++;
      outcomes.insert(outcomes.size(), o);
   endfunction

   task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
   endtask

   task check_result(logic invalid_source, logic all_burned, logic [6:0] burned_count);
      burn_outcome_type w;
      if (outcomes.size() == 0) begin
         report("result transfer with no outcome pending");
         return;
      end
      w = outcomes.pop_front();
      if (invalid_source !== w.invalid_source)
         report($sformatf("invalid_source got %0b want %0b", invalid_source,
                          w.invalid_source));
      if (all_burned !== w.all_burned)
         report($sformatf("all_burned got %0b want %0b", all_burned, w.all_burned));
      if (burned_count !== w.burned_count)
         report($sformatf("burned_count got %0d want %0d", burned_count,
                          w.burned_count));
   endtask
endclass

module testbench;

   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_WAIT  = 90;
   localparam int ITEM_TARGET = 1550;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [gbs_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // vertex_a, vertex_b, pad
   logic [gbs_pkg::REQ_USER_W-1:0] req_tuser  = '0;  // cmd
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [gbs_pkg::RSP_DATA_W-1:0] rsp_tdata;        // all_burned, burned_count
   logic [gbs_pkg::RSP_USER_W-1:0] rsp_tuser;        // invalid_source
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [gbs_pkg::COUNT_W-1:0]    csr_data   = '0;  // vertex_count

   burn_scoreboard sb = new();

   int tx_max_gap = 13;
   int rx_max_gap = 13;
   int rx_hold    = 0;
   int items_sent = 0;
   int settings   = 0;
   int idle_cycles = 0;

   graph_burning_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // check results and watch for a stuck block
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser[0], rsp_tdata[0], rsp_tdata[7:1]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold > 0) begin
            gap = rx_hold;
            rx_hold = 0;
         end else begin
            gap = $urandom_range(0, rx_max_gap);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task send_item(gbs_pkg::cmd_type cmd, logic [5:0] a, logic [5:0] b);
      int gap;
      gap = $urandom_range(0, tx_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, b, a};
      do @(posedge clock); while (!req_tready);
      sb.note_item(cmd, a, b);
      if (cmd != gbs_pkg::CMD_NOP) items_sent++;
   endtask

   // drop valid and let every outstanding result come back
   task drain();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task write_vertex_count(logic [6:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_vertex_count(value);
      settings++;
   endtask

   // mostly short-range edges so that fire spreads over several rounds
   task send_edge(int span);
      logic [5:0] a;
      logic [5:0] b;
      a = 6'($urandom_range(0, span - 1));
      if ($urandom_range(0, 9) < 7) b = a + 6'($urandom_range(0, 3));
      else b = 6'($urandom_range(0, 63));
      send_item(gbs_pkg::CMD_ADD_EDGE, a, b);
   endtask

   task run_sequence(int span);
      int len;
      int r;
      int v;
      len = $urandom_range(4, 40);
      send_item(gbs_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom));
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_edge(span);
         end else if (r < 11) begin
            send_item(gbs_pkg::CMD_NOP, 6'($urandom), 6'($urandom));
         end else if (r < 20) begin
            send_item(gbs_pkg::CMD_BURN, 6'($urandom), 6'($urandom));
         end else begin
            v = sb.pick_unburned(span);
            if (v < 0) break;
            send_item(gbs_pkg::CMD_BURN, 6'(v), 6'($urandom));
         end
      end
   endtask

   initial begin
      int vc_plan [$];
      int phase;
      int vc;
      int span;
      int budget;
      vc_plan = '{1, 64, 0, 127, 2, 63};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme vertices, self loops, repeated edges, unused command,
      // burns of an already burned source, clears
      send_item(gbs_pkg::CMD_ADD_EDGE, 6'd0, 6'd63);
      send_item(gbs_pkg::CMD_ADD_EDGE, 6'd63, 6'd0);
      send_item(gbs_pkg::CMD_ADD_EDGE, 6'd5, 6'd5);
      send_item(gbs_pkg::CMD_ADD_EDGE, 6'd0, 6'd1);
      send_item(gbs_pkg::CMD_ADD_EDGE, 6'd63, 6'd63);
      send_item(gbs_pkg::CMD_NOP, 6'd63, 6'd63);
      send_item(gbs_pkg::CMD_NOP, 6'd0, 6'd0);
      send_item(gbs_pkg::CMD_BURN, 6'd0, 6'd63);
      send_item(gbs_pkg::CMD_BURN, 6'd0, 6'd0);
      send_item(gbs_pkg::CMD_BURN, 6'd63, 6'd0);
      send_item(gbs_pkg::CMD_BURN, 6'd5, 6'd5);
      send_item(gbs_pkg::CMD_BURN, 6'd5, 6'd63);
      send_item(gbs_pkg::CMD_CLEAR, 6'd63, 6'd63);
      send_item(gbs_pkg::CMD_BURN, 6'd63, 6'd0);
      send_item(gbs_pkg::CMD_BURN, 6'd0, 6'd0);
      send_item(gbs_pkg::CMD_BURN, 6'd1, 6'd42);
      send_item(gbs_pkg::CMD_BURN, 6'd63, 6'd21);
      send_item(gbs_pkg::CMD_CLEAR, 6'd0, 6'd0);
      send_item(gbs_pkg::CMD_BURN, 6'd5, 6'd63);
      send_item(gbs_pkg::CMD_BURN, 6'd2, 6'd0);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         vc = (phase < vc_plan.size()) ? vc_plan[phase] : $urandom_range(1, 64);
         span = (vc >= 1 && vc <= 64) ? vc : 64;
         drain();
         write_vertex_count(7'(vc));
         tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 13;
         rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 13;
         if (phase == 2) begin
            // fill the block: sender streams while the result side holds off
            tx_max_gap = 0;
            rx_hold    = 400;
         end
         repeat ($urandom_range(2, 8)) send_edge(span);
         budget = items_sent + 100;
         while (items_sent < budget && items_sent < ITEM_TARGET) begin
            run_sequence(span);
         end
         phase++;
      end

      drain();
      $display("Covered %0d items, %0d burns (%0d invalid), %0d all-burned results,",
               items_sent, sb.burns, sb.invalid_burns, sb.full_results);
      $display("over %0d vertex_count settings including 0, 1, 64 and 127", settings);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/gbs_pkg.sv
sv/gbs_ram.sv
sv/gbs_ctrl.sv
sv/gbs_datapath.sv
sv/graph_burning_step.sv
verif/testbench.sv
